// ----- rtl/bta_pkg.sv -----
// Shared types and codes for the boundary-tag heap allocator.
`default_nettype none
package bta_pkg;

  localparam int REQ_W    = 13;
  localparam int OFS_W    = 12;
  localparam int STATUS_W = 2;
  localparam int POLICY_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_NOP,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [REQ_W-1:0] req;
    logic [OFS_W-1:0] rel;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/bta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bta_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata_r
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bta_front.sv -----
// Front end: accepts transactions, classifies them and queues them for the engine.
`default_nettype none
module bta_front #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_operation,
  input  wire logic [12:0]           in_request_bytes,
  input  wire logic [11:0]           in_release_offset,
  output logic                       q_valid,
  output bta_pkg::cmd_t              q_cmd,
  input  wire logic                  q_pop
);
  import bta_pkg::*;

  cmd_t       fifo_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = fifo_r[rp_r];

  always_comb begin
    cmd.req = in_request_bytes;
    cmd.rel = in_release_offset;
    if (in_operation == OP_ALLOC) begin
      cmd.kind = K_ALLOC;
    end else if (in_release_offset == '0) begin
      cmd.kind = K_NOP;
    end else if ((18'(in_release_offset) < 18'(HEADER_BYTES)) ||
                 (18'(in_release_offset) >= 18'(HEADER_BYTES + ARENA_BYTES))) begin
      cmd.kind = K_BAD;
    end else begin
      cmd.kind = K_FREE;
    end
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = (q_pop && q_valid) ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |=> (cnt_r != 2'd3)) else $error("queue count corrupt");
  a_cnt_move: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (cnt_r == $past(cnt_r) + 2'd1)) else $error("count not advanced");

endmodule
`default_nettype wire

// ----- rtl/bta_back.sv -----
// Back end: walks and rewrites the block chain held in the tag memory.
`default_nettype none
module bta_back #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [1:0]               fit_policy,
  input  wire logic                     q_valid,
  input  wire bta_pkg::cmd_t            q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    out_status,
  output logic [11:0]                   out_grant_offset
);
  import bta_pkg::*;

  localparam int AW  = $clog2(ARENA_BYTES);
  localparam int SZW = $clog2(ARENA_BYTES + 1);
  localparam int SW  = SZW + 1;
  localparam int NW  = (SZW > 14) ? SZW : 14;
  localparam int WW  = 2 + 2 * SZW;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_AW1   = 4'd3;
  localparam logic [3:0] S_AW2   = 4'd4;
  localparam logic [3:0] S_AW3   = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FPRV  = 4'd7;
  localparam logic [3:0] S_FNRD  = 4'd8;
  localparam logic [3:0] S_FNCHK = 4'd9;
  localparam logic [3:0] S_FN2RD = 4'd10;
  localparam logic [3:0] S_FN2W  = 4'd11;
  localparam logic [3:0] S_FWB   = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt, cur_r, cur_nxt, best_r, best_nxt;
  logic [AW-1:0] blk_r, blk_nxt, base_r, base_nxt;
  logic [13:0]   need_r, need_nxt;
  logic          have_r, have_nxt;
  logic [SZW-1:0] best_sz_r, best_sz_nxt, best_prev_r, best_prev_nxt;
  logic [SZW-1:0] bprev_r, bprev_nxt, size_r, size_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [11:0]   out_grant_r, out_grant_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [SZW-1:0] rd_size, rd_prev;
  logic          rd_busy, rd_start;

  logic [SW-1:0]  nxt_a, nxt_f, split_a, split_n;
  logic [SZW-1:0] rest;
  logic           fits, take, pol_first, scan_end, load;
  logic [SW-1:0]  grant_w;

  bta_ram #(.W(WW), .D(ARENA_BYTES)) u_tags (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata_r(rdata)
  );

  assign rd_size  = rdata[SZW-1:0];
  assign rd_prev  = rdata[2*SZW-1:SZW];
  assign rd_busy  = rdata[2*SZW];
  assign rd_start = rdata[2*SZW+1];

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_grant_offset = out_grant_r;

  assign nxt_a     = SW'(cur_r) + SW'(rd_size);
  assign nxt_f     = SW'(base_r) + SW'(size_r);
  assign rest      = best_sz_r - SZW'(need_r);
  assign split_a   = SW'(best_r) + SW'(need_r);
  assign split_n   = split_a + SW'(rest);
  assign grant_w   = SW'(best_r) + SW'(HEADER_BYTES);
  assign pol_first = (fit_policy != POL_BEST) && (fit_policy != POL_WORST);
  assign fits      = !rd_busy && (rd_size != '0) && (NW'(rd_size) >= NW'(need_r));
  assign take      = fits && (!have_r ||
                     ((fit_policy == POL_BEST) && (rd_size < best_sz_r)) ||
                     ((fit_policy == POL_WORST) && (rd_size > best_sz_r)));
  assign scan_end  = (fits && pol_first) || (rd_size == '0) ||
                     (nxt_a >= SW'(ARENA_BYTES));

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    blk_nxt        = blk_r;
    base_nxt       = base_r;
    need_nxt       = need_r;
    have_nxt       = have_r;
    best_sz_nxt    = best_sz_r;
    best_prev_nxt  = best_prev_r;
    bprev_nxt      = bprev_r;
    size_nxt       = size_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    q_pop = 1'b0;
    load  = 1'b0;

    unique case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = (clr_r == '0) ? {2'b10, SZW'(0), SZW'(ARENA_BYTES)} : '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(ARENA_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            K_NOP: begin
              load = 1'b1; out_status_nxt = ST_OK; out_grant_nxt = '0;
            end
            K_BAD: begin
              load = 1'b1; out_status_nxt = ST_BAD_FREE; out_grant_nxt = '0;
            end
            K_ALLOC: begin
              need_nxt  = 14'(q_cmd.req) + 14'(HEADER_BYTES);
              cur_nxt   = '0;
              have_nxt  = 1'b0;
              re        = 1'b1;
              raddr     = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              blk_nxt   = AW'(SW'(q_cmd.rel) - SW'(HEADER_BYTES));
              re        = 1'b1;
              raddr     = AW'(SW'(q_cmd.rel) - SW'(HEADER_BYTES));
              state_nxt = S_FCHK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (take) begin
          best_nxt      = cur_r;
          best_sz_nxt   = rd_size;
          best_prev_nxt = rd_prev;
          have_nxt      = 1'b1;
        end
        if (scan_end) begin
          if (have_r || take) begin
            state_nxt = S_AW1;
          end else begin
            load = 1'b1; out_status_nxt = ST_NO_SPACE; out_grant_nxt = '0;
            state_nxt = S_IDLE;
          end
        end else begin
          cur_nxt = AW'(nxt_a);
          re      = 1'b1;
          raddr   = AW'(nxt_a);
        end
      end
      S_AW1: begin
        we    = 1'b1;
        waddr = best_r;
        out_grant_nxt  = 12'(grant_w);
        out_status_nxt = ST_OK;
        if (rest >= SZW'(HEADER_BYTES)) begin
          wdata     = {2'b11, best_prev_r, SZW'(need_r)};
          state_nxt = S_AW2;
        end else begin
          wdata     = {2'b11, best_prev_r, best_sz_r};
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_AW2: begin
        we    = 1'b1;
        waddr = AW'(split_a);
        wdata = {2'b10, SZW'(need_r), rest};
        if (split_n < SW'(ARENA_BYTES)) begin
          re        = 1'b1;
          raddr     = AW'(split_n);
          cur_nxt   = AW'(split_n);
          state_nxt = S_AW3;
        end else begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_AW3: begin
        we        = 1'b1;
        waddr     = cur_r;
        wdata     = {rd_start, rd_busy, rest, rd_size};
        load      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FCHK: begin
        if (!(rd_start && rd_busy)) begin
          load = 1'b1; out_status_nxt = ST_BAD_FREE; out_grant_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          base_nxt  = blk_r;
          bprev_nxt = rd_prev;
          size_nxt  = rd_size;
          we        = 1'b1;
          waddr     = blk_r;
          wdata     = {2'b10, rd_prev, rd_size};
          if ((blk_r != '0) && (rd_prev != '0) && (SW'(rd_prev) <= SW'(blk_r))) begin
            re        = 1'b1;
            raddr     = AW'(SW'(blk_r) - SW'(rd_prev));
            cur_nxt   = AW'(SW'(blk_r) - SW'(rd_prev));
            state_nxt = S_FPRV;
          end else begin
            state_nxt = S_FNRD;
          end
        end
      end
      S_FPRV: begin
        if (rd_start && !rd_busy) begin
          we        = 1'b1;
          waddr     = blk_r;
          wdata     = '0;
          base_nxt  = cur_r;
          bprev_nxt = rd_prev;
          size_nxt  = rd_size + size_r;
        end
        state_nxt = S_FNRD;
      end
      S_FNRD, S_FN2RD: begin
        if (nxt_f < SW'(ARENA_BYTES)) begin
          re        = 1'b1;
          raddr     = AW'(nxt_f);
          cur_nxt   = AW'(nxt_f);
          state_nxt = (state_r == S_FNRD) ? S_FNCHK : S_FN2W;
        end else begin
          state_nxt = S_FWB;
        end
      end
      S_FNCHK: begin
        if (rd_start && !rd_busy) begin
          size_nxt = size_r + rd_size;
          we       = 1'b1;
          waddr    = cur_r;
          wdata    = '0;
        end
        state_nxt = S_FN2RD;
      end
      S_FN2W: begin
        we        = 1'b1;
        waddr     = cur_r;
        wdata     = {rd_start, rd_busy, size_r, rd_size};
        state_nxt = S_FWB;
      end
      S_FWB: begin
        we    = 1'b1;
        waddr = base_r;
        wdata = {2'b10, bprev_r, size_r};
        load  = 1'b1; out_status_nxt = ST_OK; out_grant_nxt = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    best_r       <= best_nxt;
    blk_r        <= blk_nxt;
    base_r       <= base_nxt;
    need_r       <= need_nxt;
    have_r       <= have_nxt;
    best_sz_r    <= best_sz_nxt;
    best_prev_r  <= best_prev_nxt;
    bprev_r      <= bprev_nxt;
    size_r       <= size_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !q_pop) else $error("pop during clear");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr)) else $error("read/write clash");
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !out_valid_r) else $error("result overwritten");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE)) else $error("pop while busy");

endmodule
`default_nettype wire

// ----- rtl/boundary_tag_heap_allocator_unit.sv -----
// Top level of the boundary-tag heap allocator.
// One transaction at a time is carried out by the chain engine; a two-entry
// queue in front keeps accepting while it works. An allocate walks the block
// chain one header per cycle; a free checks its block's tag and merges the
// block with free neighbours; a zero-offset or out-of-range free is answered
// without a tag memory access. After reset the whole tag memory is cleared
// before the first transaction starts; configuration writes are taken at
// any time.
`default_nettype none
module boundary_tag_heap_allocator_unit #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_fit_policy,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [12:0] in_request_bytes,
  input  wire logic [11:0] in_release_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [11:0]      out_grant_offset
);
  import bta_pkg::*;

  logic [POLICY_W-1:0] fit_policy_r;
  logic                q_valid, q_pop;
  cmd_t                q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      fit_policy_r <= cfg_fit_policy;
    end
  end

  bta_front #(.ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_request_bytes,
    .in_release_offset, .q_valid, .q_cmd, .q_pop
  );

  bta_back #(.ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk, .rst_n, .fit_policy(fit_policy_r), .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_ready, .out_status, .out_grant_offset
  );

endmodule
`default_nettype wire

// ----- dv/boundary_tag_heap_allocator_unit_tb.sv -----
// Testbench for the boundary-tag heap allocator: random and directed traffic with a heap predictor.
module boundary_tag_heap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  localparam int ARENA = 4096;
  localparam int HDR   = 32;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic             op;
    logic [REQ_W-1:0] req;
    logic [OFS_W-1:0] rel;
  } heap_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFS_W-1:0]    grant;
  } heap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_fit_policy = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic [12:0] in_request_bytes = '0;
  logic [11:0] in_release_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [11:0] out_grant_offset;

  boundary_tag_heap_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_fit_policy(cfg_fit_policy),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_request_bytes(in_request_bytes), .in_release_offset(in_release_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_grant_offset(out_grant_offset)
  );

  // predictor state
  int unsigned blk_size [ARENA];
  int unsigned blk_prev [ARENA];
  bit          blk_busy [ARENA];
  bit          blk_head [ARENA];
  logic [POLICY_W-1:0] policy;

  heap_op_t  pending_ops[$];
  heap_res_t expected_res[$];
  int unsigned live_grants[$];
  int errors = 0;
  int n_results = 0;
  longint cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_send = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int n_nospace = 0, n_badfree = 0;

  function automatic void heap_reset();
    for (int i = 0; i < ARENA; i++) begin
      blk_size[i] = 0; blk_prev[i] = 0; blk_busy[i] = 0; blk_head[i] = 0;
    end
    blk_size[0] = ARENA;
    blk_head[0] = 1;
  endfunction

  function automatic void link_next(int unsigned b);
    int unsigned n;
    n = b + blk_size[b];
    if (n < ARENA) blk_prev[n] = blk_size[b];
  endfunction

  function automatic heap_res_t heap_alloc(int unsigned req);
    heap_res_t r;
    int unsigned need, cur, best, rest, sz;
    bit have;
    need = HDR + req; cur = 0; best = 0; have = 0;
    while (cur < ARENA) begin
      sz = blk_size[cur];
      if (sz == 0) break;
      if (!blk_busy[cur] && sz >= need) begin
        if (!have) begin
          best = cur; have = 1;
          if (policy != POL_BEST && policy != POL_WORST) break;
        end else if (policy == POL_BEST && sz < blk_size[best]) best = cur;
        else if (policy == POL_WORST && sz > blk_size[best]) best = cur;
      end
      cur += sz;
    end
    if (!have) begin
      r.status = ST_NO_SPACE; r.grant = '0;
      return r;
    end
    rest = blk_size[best] - need;
    blk_busy[best] = 1;
    if (rest >= HDR) begin
      blk_size[best] = need;
      blk_size[best + need] = rest;
      blk_prev[best + need] = need;
      blk_busy[best + need] = 0;
      blk_head[best + need] = 1;
      link_next(best + need);
    end else begin
      link_next(best);
    end
    r.status = ST_OK;
    r.grant = OFS_W'(best + HDR);
    return r;
  endfunction

  function automatic heap_res_t heap_free(int unsigned at);
    heap_res_t r;
    int unsigned b, p, n;
    r.grant = '0;
    r.status = ST_OK;
    if (at == 0) return r;
    r.status = ST_BAD_FREE;
    if (at < HDR) return r;
    b = at - HDR;
    if (b >= ARENA || !blk_head[b] || !blk_busy[b]) return r;
    blk_busy[b] = 0;
    if (b != 0 && blk_prev[b] != 0 && blk_prev[b] <= b) begin
      p = b - blk_prev[b];
      if (blk_head[p] && !blk_busy[p]) begin
        blk_size[p] += blk_size[b];
        blk_head[b] = 0;
        b = p;
      end
    end
    n = b + blk_size[b];
    if (n < ARENA && blk_head[n] && !blk_busy[n]) begin
      blk_size[b] += blk_size[n];
      blk_head[n] = 0;
    end
    link_next(b);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic void add_op(bit op, int unsigned req, int unsigned rel);
    heap_op_t t;
    t.op = op; t.req = REQ_W'(req); t.rel = OFS_W'(rel);
    pending_ops.insert(pending_ops.size(), t);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        heap_op_t t;
        t.op = in_operation; t.req = in_request_bytes; t.rel = in_release_offset;
        expected_res.insert(expected_res.size(),
                            t.op == OP_ALLOC ? heap_alloc(t.req) : heap_free(t.rel));
      end
      if (in_valid && !in_ready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (!hold_send && pending_ops.size() > 0) begin
        heap_op_t t;
        t = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_operation <= t.op;
        in_request_bytes <= t.req;
        in_release_offset <= t.rel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        heap_res_t e;
        n_results <= n_results + 1;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result status=%0d grant=%0d", $time, out_status,
                   out_grant_offset);
          errors = errors + 1;
        end else begin
          e = expected_res.pop_front();
          if (e.status == ST_NO_SPACE) n_nospace <= n_nospace + 1;
          if (e.status == ST_BAD_FREE) n_badfree <= n_badfree + 1;
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors = errors + 1;
          end
          if (out_grant_offset !== e.grant) begin
            $display("%0t: grant_offset expected %0d actual %0d", $time, e.grant,
                     out_grant_offset);
            errors = errors + 1;
          end
          if (e.status == ST_OK && e.grant != 0)
            live_grants.insert(live_grants.size(), e.grant);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] p);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_fit_policy <= p;
    do @(posedge clk); while (!cfg_ready);
    policy = p;
    cfg_valid <= 1'b0;
  endtask

  // random traffic: mostly allocs and frees of live grants, with some noise
  task automatic random_batch(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        add_op(OP_ALLOC, $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 400), 0);
      end else if (k < 85 && live_grants.size() > 0) begin
        int j;
        j = $urandom_range(0, live_grants.size() - 1);
        add_op(OP_FREE, $urandom, live_grants[j]);
        live_grants.delete(j);
      end else begin
        add_op($urandom_range(0, 1), $urandom_range(0, 8191), $urandom_range(0, 4095));
      end
      if (pending_ops.size() > 8) begin
        while (pending_ops.size() > 2) @(posedge clk);
      end
    end
  endtask

  initial begin
    heap_reset();
    policy = POL_FIRST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, bad frees, double free, arena-end grant
    add_op(OP_FREE, 0, 0);
    add_op(OP_FREE, 0, 5);
    add_op(OP_FREE, 0, 4095);
    add_op(OP_FREE, 0, 32);
    add_op(OP_ALLOC, 8191, 0);
    add_op(OP_ALLOC, 4096, 0);
    add_op(OP_ALLOC, 4064, 0);
    add_op(OP_FREE, 0, 32);
    add_op(OP_FREE, 0, 32);
    add_op(OP_ALLOC, 0, 0);
    add_op(OP_ALLOC, 4000, 0);
    add_op(OP_ALLOC, 0, 0);
    add_op(OP_ALLOC, 0, 0);
    add_op(OP_FREE, 0, 64);
    add_op(OP_FREE, 8191, 33);
    add_op(OP_FREE, 0, 32);
    add_op(OP_FREE, 0, 4064);
    add_op(OP_ALLOC, 1, 0);
    add_op(OP_FREE, 0, 32);
    drain();
    live_grants.delete();
    hold_send = 1'b1;
    drain();
    hold_send = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      write_policy(ph[1:0]);
      random_batch(160);
      drain();
    end
    write_policy(POL_BEST);
    gaps_on = 1'b0;
    random_batch(80);
    drain();
    $display("covered %0d results over all fit policies (%0d no-space, %0d bad frees)",
             n_results, n_nospace, n_badfree);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
